[sv/akr_pkg.sv]
package akr_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] DIGIT_LO = 8'd48;
	localparam logic [7:0] DIGIT_HI = 8'd57;
	localparam logic [7:0] UPPER_LO = 8'd65;
	localparam logic [7:0] UPPER_HI = 8'd90;
	localparam logic [7:0] LOWER_LO = 8'd97;
	localparam logic [7:0] LOWER_HI = 8'd122;

	localparam logic [4:0] DIGIT_MOD  = 5'd10;
	localparam logic [5:0] LETTER_MOD = 6'd26;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_UPPER,
		CLS_LOWER,
		CLS_PASS,
		CLS_DROP
	} akr_cls_t;

	// one classified text word on its way from front to back
	typedef struct packed {
		akr_cls_t   cls;
		logic       start;
		logic [4:0] pos;
		logic [6:0] chr;
	} akr_item_t;

endpackage

[sv/akr_front.sv]
module akr_front import akr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       start_of_text,
	output akr_item_t  item_s1,
	output logic       item_valid_s1,
	input  logic       item_ready
);

	akr_item_t  item_d;
	logic       is_digit;
	logic       is_upper;
	logic       is_lower;
	logic       is_pass;
	logic [7:0] digit_off;
	logic [7:0] upper_off;
	logic [7:0] lower_off;

	assign in_ready = !item_valid_s1 || item_ready;

	always_comb begin
		is_digit  = (in_char >= DIGIT_LO) && (in_char <= DIGIT_HI);
		is_upper  = (in_char >= UPPER_LO) && (in_char <= UPPER_HI);
		is_lower  = (in_char >= LOWER_LO) && (in_char <= LOWER_HI);
		is_pass   = (in_char != 8'd0) && !in_char[7];
		digit_off = in_char - DIGIT_LO;
		upper_off = in_char - UPPER_LO;
		lower_off = in_char - LOWER_LO;

		item_d.start = start_of_text;
		item_d.chr   = in_char[6:0];
		item_d.pos   = '0;
		if (is_digit) begin
			item_d.cls = CLS_DIGIT;
			item_d.pos = digit_off[4:0];
		end else if (is_upper) begin
			item_d.cls = CLS_UPPER;
			item_d.pos = upper_off[4:0];
		end else if (is_lower) begin
			item_d.cls = CLS_LOWER;
			item_d.pos = lower_off[4:0];
		end else if (is_pass) begin
			item_d.cls = CLS_PASS;
		end else begin
			// still forwarded: it clears the letter key in the back end
			item_d.cls = CLS_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

[sv/akr_queue.sv]
module akr_queue import akr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  akr_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output akr_item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	akr_item_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push)) - CNT_W'($past(pop)))
		else $error("queue count out of step with push and pop");

endmodule

[sv/akr_back.sv]
module akr_back import akr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       decode_mode,
	input  logic       item_valid,
	output logic       item_ready,
	input  akr_item_t  item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char
);

	logic [3:0] digit_shift_q;
	logic [4:0] letter_key_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;

	logic       pop;
	logic       produce;
	logic [3:0] k;
	logic [4:0] h;
	logic [4:0] digit_sum;
	logic [3:0] digit_res;
	logic [5:0] letter_sum;
	logic [4:0] letter_res;
	logic [6:0] char_d;

	// drop words carry no output, so they never wait on the output register
	assign item_ready = (item.cls == CLS_DROP) || !out_valid_q || out_ready;
	assign pop        = item_valid && item_ready;
	assign produce    = pop && (item.cls != CLS_DROP);
	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;

	always_comb begin
		k = item.start ? 4'd0 : digit_shift_q;
		h = item.start ? 5'd0 : letter_key_q;

		// decode adds the complement so the sum never goes negative
		if (decode_mode) begin
			digit_sum  = {1'b0, item.pos[3:0]} + DIGIT_MOD - {1'b0, k};
			letter_sum = {1'b0, item.pos} + LETTER_MOD - {1'b0, h};
		end else begin
			digit_sum  = {1'b0, item.pos[3:0]} + {1'b0, k};
			letter_sum = {1'b0, item.pos} + {1'b0, h};
		end
		digit_res  = (digit_sum >= DIGIT_MOD) ? 4'(digit_sum - DIGIT_MOD) : digit_sum[3:0];
		letter_res = (letter_sum >= LETTER_MOD) ? 5'(letter_sum - LETTER_MOD)
			: letter_sum[4:0];

		case (item.cls)
			CLS_DIGIT: char_d = DIGIT_LO[6:0] + {3'b000, digit_res};
			CLS_UPPER: char_d = UPPER_LO[6:0] + {2'b00, letter_res};
			CLS_LOWER: char_d = LOWER_LO[6:0] + {2'b00, letter_res};
			default:   char_d = item.chr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_shift_q <= '0;
			letter_key_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				case (item.cls)
					CLS_DIGIT: begin
						digit_shift_q <= (k == 4'(DIGIT_MOD - 5'd1)) ? 4'd0 : k + 4'd1;
						letter_key_q  <= h;
					end
					CLS_UPPER, CLS_LOWER: begin
						digit_shift_q <= k;
						letter_key_q  <= decode_mode ? item.pos : letter_res;
					end
					default: begin
						digit_shift_q <= k;
						letter_key_q  <= '0;
					end
				endcase
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_char_q <= char_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		digit_shift_q < 4'(DIGIT_MOD))
		else $error("digit count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		letter_key_q < 5'(LETTER_MOD))
		else $error("letter key out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && item_valid && (item.cls != CLS_DROP) |-> !pop)
		else $error("word taken while output register is stalled");

endmodule

[sv/autokey_text_recoder.sv]
// Path from input accept to out_valid: front register, queue, output register.
// One word per cycle unless out_ready stalls; queue and output register decouple handshakes.
// Bytes 0 and 128..255 pass through to the back end to clear the letter key, with no output.
// Reset (arst_n low, asynchronous): queue and valid flags empty, digit count and
// letter key zero, decode_mode zero (encode).
module autokey_text_recoder import akr_pkg::*; #(
	parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       start_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	input  logic       decode_mode_we,
	input  logic       decode_mode_wdata
);

	logic      decode_mode_q;
	akr_item_t front_item_s1;
	logic      front_valid_s1;
	logic      front_ready;
	akr_item_t back_item;
	logic      back_valid;
	logic      back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
		end else if (decode_mode_we) begin
			decode_mode_q <= decode_mode_wdata;
		end
	end

	akr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_char       (in_char),
		.start_of_text (start_of_text),
		.item_s1       (front_item_s1),
		.item_valid_s1 (front_valid_s1),
		.item_ready    (front_ready)
	);

	akr_queue #(
		.DEPTH (QUEUE_ENTRIES)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid_s1),
		.push_ready (front_ready),
		.push_item  (front_item_s1),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	akr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.decode_mode (decode_mode_q),
		.item_valid  (back_valid),
		.item_ready  (back_ready),
		.item        (back_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char)
	);

endmodule
